// ===== rtl/swzn_pkg.sv =====
// Shared constants and types for the sliding-window z-score normalizer.
// No dependencies.
`default_nettype none
package swzn_pkg;
	localparam int WINDOW_RECORDS = 600;
	localparam int BAND_COUNT = 7;
	localparam int SAMPLE_BITS = 12;
	localparam int FIELD_BITS = 12;
	localparam int AGE_BITS = 10;
	localparam int BAND_BITS = 3;
	localparam logic [11:0] NOISE_FLOOR_RESET = 12'd100;

	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic [0:0] func;
		logic [11:0] band_63hz;
		logic [11:0] band_160hz;
		logic [11:0] band_400hz;
		logic [11:0] band_1khz;
		logic [11:0] band_2k5hz;
		logic [11:0] band_6k25hz;
		logic [11:0] band_16khz;
		logic [9:0] record_age;
		logic [2:0] band_select;
	} in_item_t;

	typedef struct packed {
		logic signed [7:0] z_value;
		logic uniform_window;
	} out_item_t;

	typedef struct packed {
		logic is_read;
		logic [BAND_BITS-1:0] band;
		logic [AGE_BITS-1:0] age;
		logic [BAND_COUNT*FIELD_BITS-1:0] samples;
	} cmd_t;
endpackage
`default_nettype wire

// ===== rtl/swzn_if.sv =====
// Valid/ready channel interface carrying one payload.
// Depends on nothing; payload type is a type parameter.
`default_nettype none
interface swzn_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/swzn_front.sv =====
// Front end: accept items, drop out-of-range reads, gate samples, queue commands.
// Depends on swzn_pkg.
`default_nettype none
module swzn_front #(
	parameter int WINDOW_RECORDS = swzn_pkg::WINDOW_RECORDS,
	parameter int SAMPLE_BITS = swzn_pkg::SAMPLE_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire swzn_pkg::in_item_t in_data,
	input wire logic [11:0] noise_floor,
	input wire logic enable,
	output logic cmd_valid,
	input wire logic cmd_pop,
	output swzn_pkg::cmd_t cmd_head
);
	localparam int FB = swzn_pkg::FIELD_BITS;
	localparam int BC = swzn_pkg::BAND_COUNT;
	swzn_pkg::cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	swzn_pkg::cmd_t c;
	logic [FB-1:0] raw [BC];
	logic keep, push;

	assign in_ready = enable && cnt_q != 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd_head = q_q[rd_q];

	always_comb begin
		raw[0] = in_data.band_63hz;
		raw[1] = in_data.band_160hz;
		raw[2] = in_data.band_400hz;
		raw[3] = in_data.band_1khz;
		raw[4] = in_data.band_2k5hz;
		raw[5] = in_data.band_6k25hz;
		raw[6] = in_data.band_16khz;
		c.is_read = in_data.func == swzn_pkg::FUNC_READ;
		c.band = in_data.band_select;
		c.age = in_data.record_age;
		for (int b = 0; b < BC; b++) begin
			logic [FB-1:0] v;
			v = raw[b] & FB'((1 << SAMPLE_BITS) - 1);
			c.samples[b*FB +: FB] = (v < noise_floor) ? '0 : v;
		end
		keep = !c.is_read || (32'(c.age) < WINDOW_RECORDS && 32'(c.band) < BC);
		push = in_valid && in_ready && keep;
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (cmd_pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/swzn_back.sv =====
// Back end: ring memory, running sums, z-score via divide and root search.
// Depends on swzn_pkg.
`default_nettype none
module swzn_back #(
	parameter int WINDOW_RECORDS = swzn_pkg::WINDOW_RECORDS,
	parameter int SAMPLE_BITS = swzn_pkg::SAMPLE_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_pop,
	input wire swzn_pkg::cmd_t cmd_head,
	output logic clearing,
	output logic out_valid,
	input wire logic out_ready,
	output swzn_pkg::out_item_t out_data
);
	localparam int BC = swzn_pkg::BAND_COUNT;
	localparam int FB = swzn_pkg::FIELD_BITS;
	localparam int DEPTH = WINDOW_RECORDS * BC;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(WINDOW_RECORDS);
	localparam int NV = DEPTH;
	localparam int NW = $clog2(NV + 1);
	localparam int SUMW = SAMPLE_BITS + NW;
	localparam int QW = 2 * SAMPLE_BITS + NW;
	localparam int DW = QW + NW + 1;
	localparam int AAW = SUMW + 1;
	localparam int PW = 2 * AAW;
	localparam int KW = 8;

	typedef enum logic [10:0] {
		ST_CLR = 11'b00000000001, ST_IDLE = 11'b00000000010,
		ST_PRD = 11'b00000000100, ST_PUPD = 11'b00000001000,
		ST_RRD = 11'b00000010000, ST_MUL1 = 11'b00000100000,
		ST_MUL2 = 11'b00001000000, ST_DIFF = 11'b00010000000,
		ST_DIV = 11'b00100000000, ST_SQRT = 11'b01000000000,
		ST_OUT = 11'b10000000000
	} state_t;
	state_t st_q;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	logic [SAMPLE_BITS-1:0] rdata_q;
	logic [AW-1:0] addr_q;
	logic [2:0] band_q;
	logic [SW-1:0] slot_q;
	logic full_q;
	logic [SUMW-1:0] s_q;
	logic [QW-1:0] q_q;
	swzn_pkg::cmd_t cmd_q;
	logic [DW-1:0] ns_q, ss_q, d_q;
	logic [AAW-1:0] a_q;
	logic [PW-1:0] rem_q, quo_q;
	logic [PW-1:0] num_q;
	logic [$clog2(PW+1)-1:0] bit_q;
	logic [KW-1:0] k_q;
	logic neg_q, zero_q;
	logic [SAMPLE_BITS-1:0] smp;
	logic we;
	logic [AW-1:0] waddr;
	logic [SAMPLE_BITS-1:0] wdata;
	logic [DW:0] rem_sh;
	logic [KW:0] kt;
	logic [2*KW+1:0] kt2;
	logic ob_full_q;
	swzn_pkg::out_item_t ob_q;

	assign clearing = st_q == ST_CLR;
	assign out_valid = ob_full_q;
	assign out_data = ob_q;
	assign cmd_pop = st_q == ST_IDLE && cmd_valid;
	assign smp = SAMPLE_BITS'(cmd_q.samples[band_q*FB +: FB]);
	assign kt = {1'b0, k_q} + 1'b1;
	assign kt2 = kt * kt;
	assign rem_sh = {rem_q[DW-1:0], num_q[PW-1]};

	always_comb begin
		we = 1'b0;
		waddr = addr_q;
		wdata = smp;
		if (st_q == ST_CLR) begin
			we = 1'b1;
			wdata = '0;
		end else if (st_q == ST_PUPD) we = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR;
			addr_q <= '0;
			band_q <= '0;
			slot_q <= '0;
			full_q <= 1'b0;
			s_q <= '0;
			q_q <= '0;
			ob_full_q <= 1'b0;
		end else begin
			if (ob_full_q && out_ready && st_q != ST_OUT) ob_full_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					if (32'(addr_q) == DEPTH - 1) begin
						addr_q <= '0;
						st_q <= ST_IDLE;
					end else addr_q <= addr_q + 1'b1;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd_head;
						band_q <= '0;
						if (cmd_head.is_read) begin
							// map age to slot
							if (full_q) begin
								logic [SW:0] sl;
								sl = {1'b0, slot_q} + (SW+1)'(cmd_head.age);
								if (32'(sl) >= WINDOW_RECORDS)
									sl = sl - (SW+1)'(WINDOW_RECORDS);
								addr_q <= AW'(32'(sl) * BC + 32'(cmd_head.band));
								zero_q <= 1'b0;
							end else begin
								addr_q <= AW'(32'(cmd_head.age) * BC + 32'(cmd_head.band));
								zero_q <= 32'(cmd_head.age) >= 32'(slot_q);
							end
							st_q <= ST_RRD;
						end else begin
							addr_q <= AW'(32'(slot_q) * BC);
							st_q <= ST_PRD;
						end
					end
				end
				ST_PRD: st_q <= ST_PUPD;
				ST_PUPD: begin
					// rdata_q holds old value at addr_q
					s_q <= s_q - SUMW'(rdata_q) + SUMW'(smp);
					q_q <= q_q - QW'(rdata_q) * QW'(rdata_q) + QW'(smp) * QW'(smp);
					if (band_q == 3'(BC - 1)) begin
						if (32'(slot_q) == WINDOW_RECORDS - 1) begin
							slot_q <= '0;
							full_q <= 1'b1;
						end else slot_q <= slot_q + 1'b1;
						st_q <= ST_IDLE;
					end else begin
						band_q <= band_q + 1'b1;
						addr_q <= addr_q + 1'b1;
						st_q <= ST_PRD;
					end
				end
				ST_RRD: st_q <= ST_MUL1;
				ST_MUL1: begin
					logic [SAMPLE_BITS-1:0] x;
					logic [DW-1:0] nx;
					x = zero_q ? '0 : rdata_q;
					nx = DW'(NV) * DW'(x);
					neg_q <= nx < DW'(s_q);
					a_q <= AAW'((nx < DW'(s_q)) ? DW'(s_q) - nx : nx - DW'(s_q));
					ns_q <= DW'(NV) * DW'(q_q);
					st_q <= ST_MUL2;
				end
				ST_MUL2: begin
					ss_q <= DW'(s_q) * DW'(s_q);
					num_q <= a_q * a_q;
					st_q <= ST_DIFF;
				end
				ST_DIFF: begin
					d_q <= ns_q - ss_q;
					rem_q <= '0;
					quo_q <= '0;
					bit_q <= '0;
					k_q <= '0;
					st_q <= (ns_q == ss_q) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (rem_sh >= {1'b0, d_q}) begin
						rem_q <= PW'(rem_sh - {1'b0, d_q});
						quo_q <= {quo_q[PW-2:0], 1'b1};
					end else begin
						rem_q <= PW'(rem_sh);
						quo_q <= {quo_q[PW-2:0], 1'b0};
					end
					num_q <= {num_q[PW-2:0], 1'b0};
					if (32'(bit_q) == PW - 1) st_q <= ST_SQRT;
					bit_q <= bit_q + 1'b1;
				end
				ST_SQRT: begin
					// step k up while (k+1)^2 <= quotient, stopping at k = 200
					if (k_q != 8'd200 && PW'(kt2) <= quo_q) k_q <= k_q + 1'b1;
					else st_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!ob_full_q || out_ready) begin
						if (d_q == '0) begin
							ob_q.z_value <= '0;
							ob_q.uniform_window <= 1'b1;
						end else begin
							ob_q.uniform_window <= 1'b0;
							if (neg_q) ob_q.z_value <= (k_q > 8'd128) ? -8'sd128 : -$signed(k_q);
							else ob_q.z_value <= (k_q > 8'd127) ? 8'sd127 : $signed(k_q);
						end
						ob_full_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/sliding_window_zscore_normalizer.sv =====
// Sliding-window z-score normalizer: two-entry command queue between front and back.
// Pushes occupy the back end for one memory read and write per band. Reads run
// PW = 2*(SAMPLE_BITS+$clog2(N+1)+1) = 52 divide steps by default, then a root
// search up to k, the root found (k <= 64 by default); a uniform window skips both.
// Results sit in an output register. After reset a clearing pass over
// WINDOW_RECORDS*BAND_COUNT words blocks input. Depends on swzn_pkg, swzn_if, front, back.
`default_nettype none
module sliding_window_zscore_normalizer #(
	parameter int WINDOW_RECORDS = swzn_pkg::WINDOW_RECORDS,
	parameter int SAMPLE_BITS = swzn_pkg::SAMPLE_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	swzn_if.sink in_ch,
	swzn_if.source out_ch,
	swzn_if.sink cfg_ch
);
	logic [11:0] noise_floor_q;
	logic cmd_valid, cmd_pop, clearing;
	swzn_pkg::cmd_t cmd_head;

	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) noise_floor_q <= swzn_pkg::NOISE_FLOOR_RESET;
		else if (cfg_ch.valid) noise_floor_q <= cfg_ch.data;
	end

	swzn_front #(.WINDOW_RECORDS(WINDOW_RECORDS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.noise_floor(noise_floor_q), .enable(!clearing),
		.cmd_valid, .cmd_pop, .cmd_head
	);

	swzn_back #(.WINDOW_RECORDS(WINDOW_RECORDS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_pop, .cmd_head, .clearing,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule
`default_nettype wire
